FILE: rtl/lbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbpc_pkg
// Classes, break codes, range table and pair rules for the line-break
// pair classifier.
// ----------------------------------------------------------------------------
package lbpc_pkg;

	typedef enum logic [4:0] {
		CL_XX, CL_BK, CL_CR, CL_LF, CL_SP, CL_EX, CL_QU, CL_PR, CL_OP, CL_CP, CL_CL,
		CL_IS, CL_HY, CL_NU, CL_AL, CL_HL, CL_ID, CL_H2, CL_H3, CL_CM, CL_ZW, CL_ZWJ,
		CL_BA, CL_GL, CL_WJ, CL_RI
	} lb_class_t;

	typedef enum logic [1:0] {
		ST_MUST  = 2'd0,
		ST_NO    = 2'd1,
		ST_MAY   = 2'd2,
		ST_ALNUM = 2'd3
	} lb_status_t;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_MAND,
		MK_PROH,
		MK_OPP
	} lb_marker_t;

	typedef enum logic [2:0] {
		REG_UNICODE_ZONE_MAX,
		REG_CONTROL_ZONE_MIN,
		REG_CONTROL_ZONE_MAX,
		REG_NATIVE_WORD_MIN,
		REG_BASE_SPACE_MAX,
		REG_MARKER_MANDATORY,
		REG_MARKER_PROHIBITED,
		REG_MARKER_OPPORTUNISTIC
	} lb_reg_t;

	localparam int unsigned CP_W      = 64;
	localparam int unsigned TBL_W     = 17;
	localparam int unsigned NRANGES   = 47;
	localparam logic [CP_W-1:0] NATIVE_MAX = 64'h0000_0000_00FF_FFFF;

	localparam logic [TBL_W-1:0] RNG_LO [NRANGES] = '{
		17'h0000A, 17'h0000D, 17'h00020, 17'h00021, 17'h00022, 17'h00024, 17'h00027,
		17'h00028, 17'h00029, 17'h0002C, 17'h0002D, 17'h0002E, 17'h00030, 17'h0003A,
		17'h0003F, 17'h00041, 17'h0005B, 17'h0005D, 17'h00061, 17'h0007B, 17'h0007D,
		17'h000A0, 17'h000A3, 17'h000A5, 17'h000C0, 17'h00300, 17'h00370, 17'h00400,
		17'h005D0, 17'h0200B, 17'h0200D, 17'h02010, 17'h02011, 17'h02018, 17'h02028,
		17'h0202F, 17'h02060, 17'h02E80, 17'h03001, 17'h03002, 17'h03041, 17'h03400,
		17'h04E00, 17'h0AC00, 17'h0AC01, 17'h0F900, 17'h1F1E6
	};

	localparam logic [TBL_W-1:0] RNG_HI [NRANGES] = '{
		17'h0000B, 17'h0000D, 17'h00020, 17'h00021, 17'h00022, 17'h00024, 17'h00027,
		17'h00028, 17'h00029, 17'h0002C, 17'h0002D, 17'h0002E, 17'h00039, 17'h0003B,
		17'h0003F, 17'h0005A, 17'h0005B, 17'h0005D, 17'h0007A, 17'h0007B, 17'h0007D,
		17'h000A0, 17'h000A3, 17'h000A5, 17'h0024F, 17'h0036F, 17'h003FF, 17'h0052F,
		17'h005EA, 17'h0200B, 17'h0200D, 17'h02010, 17'h02011, 17'h0201F, 17'h02029,
		17'h0202F, 17'h02060, 17'h02FFF, 17'h03001, 17'h03002, 17'h030FF, 17'h04DBF,
		17'h09FFF, 17'h0AC00, 17'h0D7A3, 17'h0FAFF, 17'h1F1FF
	};

	localparam lb_class_t RNG_CLS [NRANGES] = '{
		CL_LF, CL_CR, CL_SP, CL_EX, CL_QU, CL_PR, CL_QU, CL_OP, CL_CP,
		CL_IS, CL_HY, CL_IS, CL_NU, CL_IS, CL_EX, CL_AL, CL_OP, CL_CP,
		CL_AL, CL_OP, CL_CP, CL_GL, CL_PR, CL_PR, CL_AL, CL_CM, CL_AL,
		CL_AL, CL_HL, CL_ZW, CL_ZWJ, CL_BA, CL_GL, CL_QU, CL_BK, CL_GL,
		CL_WJ, CL_ID, CL_BA, CL_CL, CL_ID, CL_ID, CL_ID, CL_H2, CL_H3,
		CL_ID, CL_RI
	};

	// ranges are disjoint, so at most one hits
	function automatic lb_class_t table_class(input logic [TBL_W-1:0] cp);
		lb_class_t c;
		c = CL_XX;
		for (int i = 0; i < NRANGES; i++) begin
			if (cp >= RNG_LO[i] && cp <= RNG_HI[i]) begin
				c = RNG_CLS[i];
			end
		end
		return c;
	endfunction

	function automatic logic is_alpha(input lb_class_t c);
		return c == CL_AL || c == CL_HL || c == CL_ID || c == CL_H2 || c == CL_H3;
	endfunction

	function automatic logic is_word(input lb_class_t c);
		return is_alpha(c) || c == CL_NU;
	endfunction

	function automatic lb_status_t pair_status(input lb_class_t p, input lb_class_t c);
		lb_status_t s;
		if (p == CL_CR && c == CL_LF) s = ST_NO;
		else if (p == CL_BK || p == CL_CR || p == CL_LF || c == CL_LF) s = ST_MUST;
		else if (p == CL_WJ || c == CL_WJ) s = ST_NO;
		else if (p == CL_ZW) s = ST_MAY;
		else if (p == CL_GL && c != CL_SP) s = ST_NO;
		else if (p == CL_SP && c == CL_SP) s = ST_NO;
		else if (is_word(p) && is_word(c)) s = ST_NO;
		else if (p == CL_OP) s = ST_NO;
		else if (c == CL_CL || c == CL_CP || c == CL_EX) s = ST_NO;
		else if (c == CL_GL) s = ST_NO;
		else if (p == CL_QU) s = ST_NO;
		else if (is_alpha(p) && c == CL_PR) s = ST_ALNUM;
		else s = ST_MAY;
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/line_break_pair_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_break_pair_classifier
// Classifies each code point into a line-break class and judges the boundary
// with the previous class through the pair rules, unless a marker code point sets it.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid / tready    tdata = code_point, tuser = start_of_text
// m_axis    out  tvalid / tready    tdata[1:0] = break_status
// cfg       in   cfg_wr_en          cfg_index, cfg_data (64 bit)
//
// Three register stages: input beat, class, result. One beat per cycle
// sustained while m_axis keeps taking results.
// The class stage updates the previous-class register as it hands off.
// arst_n clears valids, previous class (XX) and the first-item flag; the
// config registers return to their defaults.
// A stall on m_axis backs up stage by stage; nothing is dropped.
// ----------------------------------------------------------------------------
module line_break_pair_classifier
	import lbpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] code_point
	input  wire logic [0:0]  s_axis_tuser,   // [0] start_of_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [1:0] break_status, [7:2] zero
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [CP_W-1:0] uz_max_q, cz_min_q, cz_max_q, nw_min_q, bs_max_q;
	logic [CP_W-1:0] mk_mand_q, mk_proh_q, mk_opp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uz_max_q  <= 64'h0000_0000_0010_FFFF;
			cz_min_q  <= 64'h0000_0000_0011_0000;
			cz_max_q  <= 64'h0000_0000_0011_FFFF;
			nw_min_q  <= 64'h0000_0000_0012_0000;
			bs_max_q  <= 64'h0000_0000_FFFF_FFFF;
			mk_mand_q <= 64'h0000_0000_0011_0000;
			mk_proh_q <= 64'h0000_0000_0011_0001;
			mk_opp_q  <= 64'h0000_0000_0011_0002;
		end else if (cfg_wr_en) begin
			unique case (lb_reg_t'(cfg_index))
				REG_UNICODE_ZONE_MAX:     uz_max_q  <= cfg_data;
				REG_CONTROL_ZONE_MIN:     cz_min_q  <= cfg_data;
				REG_CONTROL_ZONE_MAX:     cz_max_q  <= cfg_data;
				REG_NATIVE_WORD_MIN:      nw_min_q  <= cfg_data;
				REG_BASE_SPACE_MAX:       bs_max_q  <= cfg_data;
				REG_MARKER_MANDATORY:     mk_mand_q <= cfg_data;
				REG_MARKER_PROHIBITED:    mk_proh_q <= cfg_data;
				REG_MARKER_OPPORTUNISTIC: mk_opp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and advance chain
	logic s1_v, s2_v, out_v;
	logic out_free, s2_free, s1_free, s2_adv, s1_adv, in_acc;

	assign out_free      = !out_v || m_axis_tready;
	assign s2_adv        = s2_v && out_free;
	assign s2_free       = !s2_v || out_free;
	assign s1_adv        = s1_v && s2_free;
	assign s1_free       = !s1_v || s2_free;
	assign s_axis_tready = s1_free;
	assign in_acc        = s_axis_tvalid && s1_free;

	// stage 1: input beat
	logic [CP_W-1:0] cp_s1;
	logic            start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_free) begin
			s1_v <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cp_s1    <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
		end
	end

	// classification
	lb_class_t  cls_c;
	lb_marker_t mark_c;
	logic       in_uz, in_tbl_span, in_cz, in_nw;

	always_comb begin
		in_uz       = cp_s1 <= uz_max_q;
		in_tbl_span = cp_s1[CP_W-1:TBL_W] == '0;
		in_cz       = cp_s1 >= cz_min_q && cp_s1 <= cz_max_q;
		in_nw       = cp_s1 <= bs_max_q && cp_s1 >= nw_min_q && cp_s1 <= NATIVE_MAX;

		if (cp_s1 == mk_mand_q)      mark_c = MK_MAND;
		else if (cp_s1 == mk_proh_q) mark_c = MK_PROH;
		else if (cp_s1 == mk_opp_q)  mark_c = MK_OPP;
		else                         mark_c = MK_NONE;

		if (in_uz) begin
			cls_c = in_tbl_span ? table_class(cp_s1[TBL_W-1:0]) : CL_XX;
		end else if (mark_c == MK_MAND) begin
			cls_c = CL_BK;
		end else if (mark_c == MK_PROH) begin
			cls_c = CL_GL;
		end else if (mark_c == MK_OPP) begin
			cls_c = CL_BA;
		end else if (in_cz) begin
			cls_c = CL_BK;
		end else if (in_nw) begin
			cls_c = CL_ID;
		end else begin
			cls_c = CL_XX;
		end
	end

	// stage 2: class and marker
	lb_class_t  cls_s2;
	lb_marker_t mark_s2;
	logic       start_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_free) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cls_s2   <= cls_c;
			mark_s2  <= mark_c;
			start_s2 <= start_s1;
		end
	end

	// pair judgement against the previous class
	lb_class_t  prev_q;
	logic       seen_q;
	lb_class_t  prev_eff;
	logic       seen_eff;
	lb_status_t status_c;

	always_comb begin
		prev_eff = start_s2 ? CL_XX : prev_q;
		seen_eff = !start_s2 && seen_q;
		if (!seen_eff) begin
			status_c = ST_MUST;
		end else begin
			case (mark_s2)
				MK_MAND: status_c = ST_MUST;
				MK_PROH: status_c = ST_NO;
				MK_OPP:  status_c = ST_MAY;
				default: status_c = pair_status(prev_eff, cls_s2);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CL_XX;
			seen_q <= 1'b0;
		end else if (s2_adv) begin
			prev_q <= cls_s2;
			seen_q <= 1'b1;
		end
	end

	// stage 3: result
	lb_status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (out_free) begin
			out_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			status_q <= status_c;
		end
	end

	assign m_axis_tvalid = out_v;
	assign m_axis_tdata  = {6'b0, status_q};

	// checks
	a_first_must: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv && (start_s2 || !seen_q) |=> status_q == ST_MUST)
		else $error("first beat of a run did not give must break");

	a_mand_marker: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv && mark_s2 == MK_MAND |=> status_q == ST_MUST)
		else $error("mandatory marker did not give must break");

	a_seen_set: assert property (@(posedge clk) disable iff (!arst_n)
		s2_adv |=> seen_q)
		else $error("first-item flag not set after a beat");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v |-> s_axis_tready)
		else $error("input stalled with an empty input stage");

endmodule
`default_nettype wire
